>>> hw/rtl/mmet_pkg.sv
// ---------------------------------------------------------------------------
// mmet_pkg: shared types and constants for the MUS to MIDI transcoder
// Transaction types, MIDI codes, MUS event kinds and the controller map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmet_pkg;

    localparam int CHANNELS       = 16;
    localparam int CHAN_BITS      = 4;
    localparam int DELTA_BITS_DEF = 28;
    localparam int DELTA_BITS_MAX = 28;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] META        = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;

    localparam logic [6:0] VEL_RESET     = 7'd64;
    localparam logic [3:0] DRUM_CHAN     = 4'd9;
    localparam logic [4:0] MAP_UNASSIGNED = 5'd16;
    localparam logic [4:0] CHAN_SKIP     = 5'd9;

    localparam logic [2:0] KIND_RELEASE = 3'd0;
    localparam logic [2:0] KIND_PLAY    = 3'd1;
    localparam logic [2:0] KIND_BEND    = 3'd2;
    localparam logic [2:0] KIND_SYS     = 3'd3;
    localparam logic [2:0] KIND_CTRL    = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd6;

    typedef struct packed {
        logic [7:0] score_byte;
        logic       is_final;
    } t_in;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_of_run;
        logic       end_of_track;
    } t_out;

    typedef struct packed {
        logic [DELTA_BITS_MAX-1:0] delta;
        logic [2:0]                groups;
        logic                      has_event;
        logic [7:0]                ev0;
        logic [7:0]                ev1;
        logic [7:0]                ev2;
        logic                      ev_len3;
        logic                      has_end;
    } t_cmd;

    function automatic logic [7:0] ctl_map(input logic [7:0] n);
        logic [7:0] r;
        case (n)
            8'd0:    r = 8'd0;
            8'd1:    r = 8'd0;
            8'd2:    r = 8'd1;
            8'd3:    r = 8'd7;
            8'd4:    r = 8'd10;
            8'd5:    r = 8'd11;
            8'd6:    r = 8'd91;
            8'd7:    r = 8'd93;
            8'd8:    r = 8'd64;
            8'd9:    r = 8'd67;
            8'd10:   r = 8'd120;
            8'd11:   r = 8'd123;
            8'd12:   r = 8'd126;
            8'd13:   r = 8'd127;
            8'd14:   r = 8'd121;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mmet_queue.sv
// ---------------------------------------------------------------------------
// mmet_queue: command queue between parser and byte emitter
// Small register FIFO of decoded event commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmet_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mmet_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output mmet_pkg::t_cmd      o_head
);

    localparam int DEPTH = mmet_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    mmet_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");

endmodule

`default_nettype wire

>>> hw/rtl/mmet_front.sv
// ---------------------------------------------------------------------------
// mmet_front: MUS score parser
// Tracks event phase, channel map, velocities and delta time; turns each
// input transaction into at most one queued command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmet_front #(
    parameter int DELTA_BITS = mmet_pkg::DELTA_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire mmet_pkg::t_in  i_in_data,
    output logic                o_in_stall,
    input  wire logic           i_q_full,
    output logic                o_push,
    output mmet_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] PH_DESC  = 2'd0;
    localparam logic [1:0] PH_DATA1 = 2'd1;
    localparam logic [1:0] PH_DATA2 = 2'd2;
    localparam logic [1:0] PH_DELAY = 2'd3;
    localparam int DW = mmet_pkg::DELTA_BITS_MAX;
    localparam int NC = mmet_pkg::CHANNELS;
    localparam int CB = mmet_pkg::CHAN_BITS;
    localparam logic [DELTA_BITS-1:0] DELTA_MAX = '1;

    logic [1:0]            r_phase, n_phase;
    logic [2:0]            r_kind;
    logic [CB-1:0]         r_chan, r_mc;
    logic                  r_hd;
    logic [7:0]            r_first;
    logic [DELTA_BITS-1:0] r_accum, r_pending;
    logic [4:0]            r_map [NC];
    logic [4:0]            r_next;
    logic [6:0]            r_vel [NC];
    logic                  r_done;

    logic            acc, fin;
    logic [7:0]      b;
    logic            is_desc, is_data1, is_data2, is_delay;
    logic [CB-1:0]   desc_ch, desc_mc;
    logic [2:0]      desc_kind;
    logic [4:0]      map_entry, alloc_base;
    logic            unassigned, alloc_full;
    logic [2:0]      ctx_kind;
    logic [CB-1:0]   ctx_chan, ctx_mc;
    logic            ctx_hd;
    logic [7:0]      d1, d1_first, v, first;
    logic            do_d1, do_d2, d1_to_d2, d1_event, ev_valid, is_end, after;
    logic [6:0]      vel_rem;
    logic [7:0]      e0, e1, e2;
    logic            e3;
    logic [DELTA_BITS-1:0] acc_next, pend_sat;
    logic [DELTA_BITS:0]   sum;
    logic [DW-1:0]         d28;

    assign acc        = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign b          = i_in_data.score_byte;
    assign fin        = i_in_data.is_final;

    assign is_desc  = (r_phase == PH_DESC);
    assign is_data1 = (r_phase == PH_DATA1);
    assign is_data2 = (r_phase == PH_DATA2);
    assign is_delay = (r_phase == PH_DELAY);

    assign desc_ch    = b[3:0];
    assign desc_kind  = b[6:4];
    assign map_entry  = r_map[desc_ch];
    assign unassigned = map_entry[4];
    assign alloc_base = (r_next == mmet_pkg::CHAN_SKIP) ? 5'd10 : r_next;
    assign alloc_full = alloc_base[4];
    assign desc_mc    = !unassigned ? map_entry[3:0] : (alloc_full ? '0 : alloc_base[3:0]);

    assign ctx_kind = is_desc ? desc_kind : r_kind;
    assign ctx_chan = is_desc ? desc_ch : r_chan;
    assign ctx_mc   = is_desc ? desc_mc : r_mc;
    assign ctx_hd   = is_desc ? b[7] : r_hd;

    assign d1       = is_data1 ? b : 8'd0;
    assign do_d1    = is_data1 || (is_desc && desc_kind != mmet_pkg::KIND_END && fin);
    assign d1_to_d2 = (ctx_kind == mmet_pkg::KIND_PLAY && d1[7])
                   || (ctx_kind == mmet_pkg::KIND_CTRL);
    assign d1_first = (ctx_kind == mmet_pkg::KIND_PLAY) ? {1'b0, d1[6:0]} : d1;
    assign d1_event = (ctx_kind == mmet_pkg::KIND_RELEASE)
                   || (ctx_kind == mmet_pkg::KIND_PLAY && !d1[7])
                   || (ctx_kind == mmet_pkg::KIND_BEND)
                   || (ctx_kind == mmet_pkg::KIND_SYS);
    assign do_d2    = is_data2 || (do_d1 && d1_to_d2 && fin);
    assign v        = is_data2 ? b : 8'd0;
    assign first    = is_data2 ? r_first : d1_first;
    assign vel_rem  = r_vel[ctx_chan];
    assign ev_valid = (do_d1 && d1_event) || do_d2;
    assign is_end   = (is_desc && desc_kind == mmet_pkg::KIND_END) || fin;
    assign after    = ev_valid || (do_d1 && !d1_event && !d1_to_d2);

    always_comb begin
        e0 = mmet_pkg::ST_CTRL | {4'd0, ctx_mc};
        e1 = 8'd0;
        e2 = 8'd0;
        e3 = 1'b1;
        if (do_d2) begin
            if (ctx_kind == mmet_pkg::KIND_PLAY) begin
                e0 = mmet_pkg::ST_NOTE_ON | {4'd0, ctx_mc};
                e1 = first;
                e2 = {1'b0, is_data2 ? v[6:0] : vel_rem};
            end else if (first == 8'd0) begin
                e0 = mmet_pkg::ST_PROG | {4'd0, ctx_mc};
                e1 = {1'b0, v[6:0]};
                e3 = 1'b0;
            end else begin
                e1 = (first < 8'd15) ? mmet_pkg::ctl_map(first) : first;
                e2 = {1'b0, v[6:0]};
            end
        end else begin
            case (ctx_kind)
                mmet_pkg::KIND_RELEASE: begin
                    e0 = mmet_pkg::ST_NOTE_OFF | {4'd0, ctx_mc};
                    e1 = {1'b0, d1[6:0]};
                end
                mmet_pkg::KIND_PLAY: begin
                    e0 = mmet_pkg::ST_NOTE_ON | {4'd0, ctx_mc};
                    e1 = {1'b0, d1[6:0]};
                    e2 = {1'b0, vel_rem};
                end
                mmet_pkg::KIND_BEND: begin
                    e0 = mmet_pkg::ST_BEND | {4'd0, ctx_mc};
                    e1 = {1'b0, d1[0], 6'd0};
                    e2 = {1'b0, d1[7:1]};
                end
                default: begin
                    e1 = (d1 < 8'd15) ? mmet_pkg::ctl_map(d1) : 8'd0;
                end
            endcase
        end
    end

    assign acc_next = {r_accum[DELTA_BITS-8:0], b[6:0]};
    assign sum      = {1'b0, r_pending} + {1'b0, acc_next};
    assign pend_sat = sum[DELTA_BITS] ? DELTA_MAX : sum[DELTA_BITS-1:0];
    assign d28      = DW'(r_pending);

    always_comb begin
        n_phase = r_phase;
        if (after) begin
            n_phase = ctx_hd ? PH_DELAY : PH_DESC;
        end else if (is_desc) begin
            n_phase = PH_DATA1;
        end else if (do_d1 && d1_to_d2) begin
            n_phase = PH_DATA2;
        end else if (is_delay && !b[7]) begin
            n_phase = PH_DESC;
        end
    end

    assign o_push = acc && !r_done && (ev_valid || is_end);

    always_comb begin
        o_cmd.delta     = d28;
        o_cmd.groups    = (|d28[27:21]) ? 3'd4 : (|d28[20:14]) ? 3'd3 :
                          (|d28[13:7]) ? 3'd2 : 3'd1;
        o_cmd.has_event = ev_valid;
        o_cmd.ev0       = e0;
        o_cmd.ev1       = e1;
        o_cmd.ev2       = e2;
        o_cmd.ev_len3   = e3;
        o_cmd.has_end   = is_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DESC;
            r_kind    <= '0;
            r_chan    <= '0;
            r_mc      <= '0;
            r_hd      <= 1'b0;
            r_first   <= '0;
            r_accum   <= '0;
            r_pending <= '0;
            r_next    <= '0;
            r_done    <= 1'b0;
            for (int i = 0; i < NC; i++) begin
                r_map[i] <= (i == NC - 1) ? {1'b0, mmet_pkg::DRUM_CHAN}
                                          : mmet_pkg::MAP_UNASSIGNED;
                r_vel[i] <= mmet_pkg::VEL_RESET;
            end
        end else if (acc && !r_done) begin
            r_phase <= n_phase;
            if (is_desc) begin
                r_kind <= desc_kind;
                r_chan <= desc_ch;
                r_mc   <= desc_mc;
                r_hd   <= b[7];
                if (unassigned) begin
                    r_map[desc_ch] <= alloc_full ? 5'd0 : alloc_base;
                    r_next         <= alloc_full ? alloc_base : alloc_base + 5'd1;
                end
            end
            if (do_d1 && d1_to_d2) begin
                r_first <= d1_first;
            end
            if (is_data2 && r_kind == mmet_pkg::KIND_PLAY) begin
                r_vel[r_chan] <= b[6:0];
            end
            if (ev_valid) begin
                r_pending <= '0;
            end
            if (after && ctx_hd) begin
                r_accum <= '0;
            end
            if (is_delay) begin
                r_accum <= acc_next;
                if (!b[7]) begin
                    r_pending <= pend_sat;
                end
            end
            if (is_end) begin
                r_done <= 1'b1;
            end
        end
    end

    a_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.has_end) |=> r_done) else $error("end not latched");

    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_done) |-> !o_push) else $error("command after end of track");

endmodule

`default_nettype wire

>>> hw/rtl/mmet_back.sv
// ---------------------------------------------------------------------------
// mmet_back: MIDI byte emitter
// Expands the queued command into delta bytes, event bytes and the
// end-of-track meta event, one byte per output transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmet_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire mmet_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output mmet_pkg::t_out      o_out_data,
    input  wire logic           i_out_stall
);

    logic [3:0]     r_pos;
    logic           r_out_valid;
    mmet_pkg::t_out r_out;

    logic       load, last, in_delta, in_ev;
    logic [3:0] groups4, evlen, total, g, k_ev, k_end;
    logic [6:0] grp;
    logic [7:0] byte_val;

    assign load    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign groups4 = {1'b0, i_head.groups};
    assign evlen   = i_head.has_event ? groups4 + (i_head.ev_len3 ? 4'd3 : 4'd2) : 4'd0;
    assign total   = evlen + (i_head.has_end ? 4'd4 : 4'd0);
    assign last    = (r_pos == total - 4'd1);
    assign in_delta = i_head.has_event && (r_pos < groups4);
    assign in_ev    = i_head.has_event && (r_pos < evlen);
    assign g       = groups4 - 4'd1 - r_pos;
    assign k_ev    = r_pos - groups4;
    assign k_end   = r_pos - evlen;

    always_comb begin
        case (g[1:0])
            2'd0:    grp = i_head.delta[6:0];
            2'd1:    grp = i_head.delta[13:7];
            2'd2:    grp = i_head.delta[20:14];
            default: grp = i_head.delta[27:21];
        endcase
        if (in_delta) begin
            byte_val = {(g[1:0] != 2'd0), grp};
        end else if (in_ev) begin
            case (k_ev[1:0])
                2'd0:    byte_val = i_head.ev0;
                2'd1:    byte_val = i_head.ev1;
                default: byte_val = i_head.ev2;
            endcase
        end else begin
            case (k_end[1:0])
                2'd1:    byte_val = mmet_pkg::META;
                2'd2:    byte_val = mmet_pkg::META_EOT;
                default: byte_val = 8'h00;
            endcase
        end
    end

    assign o_pop       = load && last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.midi_byte    <= byte_val;
            r_out.last_of_run  <= last;
            r_out.end_of_track <= last && i_head.has_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_pos       <= last ? 4'd0 : r_pos + 4'd1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    a_eot_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.end_of_track) |-> r_out.last_of_run)
        else $error("end of track not on last byte");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 4'd10) else $error("byte position out of range");

endmodule

`default_nettype wire

>>> hw/rtl/mus_to_midi_event_transcoder.sv
// ---------------------------------------------------------------------------
// mus_to_midi_event_transcoder: MUS score body to MIDI track body
// Input channel (i_in_valid / i_in_data / o_in_stall) takes one MUS score
// byte per transaction, is_final marking the last byte of the score.
// Output channel (o_out_valid / o_out_data / i_out_stall) gives one MIDI
// byte per transaction; last_of_run flags the final byte caused by an
// input, end_of_track the closing byte of FF 2F 00.
// The parser takes one input per cycle while the queue is not full and pushes
// at most one command into a 4-entry queue; the emitter sends one byte per
// cycle from the queue head while the receiver does not stall. An input's
// command is registered in the queue, then its first byte in the output register.
// Sustained rate is set by the emitter: one output byte per cycle while the
// receiver does not stall; an input produces up to 11 bytes.
// o_in_stall rises only when the queue is full, which happens when the
// receiver holds i_out_stall or bytes are produced faster than drained.
// A stalled output byte is held in the output register.
// Synchronous reset clears the parser, channel map (MUS 15 on MIDI 9),
// velocities (64), the queue and the output valid; no clearing pass.
// After the end of track further inputs are taken and ignored.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mus_to_midi_event_transcoder #(
    parameter int DELTA_BITS = mmet_pkg::DELTA_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire mmet_pkg::t_in  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mmet_pkg::t_out      o_out_data,
    input  wire logic           i_out_stall
);

    logic           push, pop, q_full, q_valid;
    mmet_pkg::t_cmd cmd, head;

    mmet_front #(
        .DELTA_BITS (DELTA_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    mmet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    mmet_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
